// ===== rtl/shared_palette_slot_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Shared palette slot allocator: assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHARED_PALETTE_SLOT_ALLOCATOR_DEFINES_SVH
`define SHARED_PALETTE_SLOT_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPSA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Expression must never be true.
`define SPSA_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== rtl/spsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Shared palette slot allocator package
// Default sizes, field widths, controller states and command type.
// ----------------------------------------------------------------------------
package spsa_pkg;

	localparam int SLOT_COUNT_DEF = 15;
	localparam int TYPE_BITS_DEF  = 4;

	// Widths of the request and result fields on the ports.
	localparam int FIELD_BITS = 4;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} spsa_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic exec;
	} spsa_cmd_t;

endpackage

// ===== rtl/spsa_datapath.sv =====
// ----------------------------------------------------------------------------
// Shared palette slot allocator datapath
// Slot table, request register, first-match search, claim mask and result.
// ----------------------------------------------------------------------------
module spsa_datapath import spsa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int TYPE_BITS  = TYPE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spsa_cmd_t             cmd,
	input  logic [FIELD_BITS-1:0] owner_type,
	input  logic [FIELD_BITS-1:0] claim_count,
	output logic                  granted,
	output logic [FIELD_BITS-1:0] slot_index
);

	localparam int IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int EXT_BITS = SLOT_COUNT + (1 << FIELD_BITS);

	logic [TYPE_BITS-1:0]  req_type_q;
	logic [FIELD_BITS-1:0] req_count_q;
	logic [SLOT_COUNT-1:0] taken_q;
	logic [TYPE_BITS-1:0]  owner_q [SLOT_COUNT];
	logic                  granted_q;
	logic [FIELD_BITS-1:0] index_q;

	logic [TYPE_BITS+FIELD_BITS-1:0] type_wide;
	logic [SLOT_COUNT-1:0]           hit;
	logic [SLOT_COUNT-1:0]           first;
	logic [IDX_BITS-1:0]             first_idx;
	logic [IDX_BITS+FIELD_BITS-1:0]  idx_wide;
	logic                            any_hit;
	logic                            fresh;
	logic [EXT_BITS-1:0]             first_ext;
	logic [EXT_BITS-1:0]             range_ext;
	logic [SLOT_COUNT-1:0]           claim;

	// The tag is masked to the stored width, or zero-extended when wider.
	assign type_wide = {{TYPE_BITS{1'b0}}, owner_type};

	always_comb begin
		for (int k = 0; k < SLOT_COUNT; k++) begin
			hit[k] = !taken_q[k] || (owner_q[k] == req_type_q);
		end
	end

	// Isolate the lowest set bit of the hit vector.
	assign first   = hit & (~hit + SLOT_COUNT'(1));
	assign any_hit = |hit;
	assign fresh   = |(first & ~taken_q);

	always_comb begin
		first_idx = '0;
		for (int k = 0; k < SLOT_COUNT; k++) begin
			if (first[k]) begin
				first_idx = first_idx | IDX_BITS'(k);
			end
		end
	end

	assign idx_wide = {{FIELD_BITS{1'b0}}, first_idx};

	// Slots at or above the first hit and below it plus the count. The mask is
	// built wide enough for any count; bits past the table are dropped.
	assign first_ext = {{(EXT_BITS-SLOT_COUNT){1'b0}}, first};
	assign range_ext = ~(first_ext - EXT_BITS'(1)) &
		((first_ext << req_count_q) - EXT_BITS'(1));
	assign claim     = fresh ? range_ext[SLOT_COUNT-1:0] : '0;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q  <= type_wide[TYPE_BITS-1:0];
			req_count_q <= claim_count;
		end
		if (cmd.exec) begin
			granted_q <= any_hit;
			index_q   <= idx_wide[FIELD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			for (int k = 0; k < SLOT_COUNT; k++) begin
				owner_q[k] <= '0;
			end
		end else if (cmd.exec) begin
			for (int k = 0; k < SLOT_COUNT; k++) begin
				if (claim[k]) begin
					taken_q[k] <= 1'b1;
					owner_q[k] <= req_type_q;
				end
			end
		end
	end

	assign granted    = granted_q;
	assign slot_index = index_q;

endmodule

// ===== rtl/spsa_controller.sv =====
// ----------------------------------------------------------------------------
// Shared palette slot allocator controller
// Input handshake, request sequencing and output valid register.
// ----------------------------------------------------------------------------
`include "shared_palette_slot_allocator_defines.svh"

module spsa_controller import spsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output spsa_cmd_t cmd
);

	spsa_state_t state_q;
	spsa_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	// The result register can take a new result when empty or draining.
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				cmd.load_req = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`SPSA_ASSERT_NXT(a_accept_to_exec, in_valid && !in_stall, state_q == ST_EXEC, "accepted request did not start")
	`SPSA_ASSERT_NXT(a_blocked_holds, (state_q == ST_EXEC) && out_valid_q && out_stall, state_q == ST_EXEC, "request left while result blocked")
	`SPSA_ASSERT_NXT(a_exec_gives_result, cmd.exec, out_valid_q, "executed request left no result")
	`SPSA_ASSERT_NEVER(a_no_load_during_exec, cmd.exec && cmd.load_req, "load and execute in one cycle")

endmodule

// ===== rtl/shared_palette_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Shared palette slot allocator
// Grants palette slots to owner types from a table of taken flags and owners.
//
//   Channel   Handshake            Fields
//   request   in_valid / in_stall  owner_type[3:0], claim_count[3:0]
//   result    out_valid/ out_stall granted, slot_index[3:0]
//
// A request is registered in the idle state; the execute state then searches the
// table, updates it and loads the result register. The search, claim mask and
// table update of all slots happen together when the execute command is issued.
// A new request may transfer while a result still waits in the output register.
// A request holds in the execute state while the output register is full and
// stalled. Reset clears the whole table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shared_palette_slot_allocator import spsa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int TYPE_BITS  = TYPE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FIELD_BITS-1:0] owner_type,
	input  logic [FIELD_BITS-1:0] claim_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  granted,
	output logic [FIELD_BITS-1:0] slot_index
);

	spsa_cmd_t cmd;

	spsa_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	spsa_datapath #(
		.SLOT_COUNT (SLOT_COUNT),
		.TYPE_BITS  (TYPE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.owner_type  (owner_type),
		.claim_count (claim_count),
		.granted     (granted),
		.slot_index  (slot_index)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared palette slot allocator testbench
// Drives owner requests through the valid/stall request channel. A scoreboard
// class keeps its own copy of the slot table and predicts each grant. Every
// result transfer is checked against the oldest prediction, with random idling
// on both sides, a long receiver hold-off and a drain pause by the sender.
// ----------------------------------------------------------------------------
module tb import spsa_pkg::*;;

	localparam int NUM_SLOTS    = SLOT_COUNT_DEF;
	localparam int OWNER_BITS   = TYPE_BITS_DEF;
	localparam int RANDOM_ITEMS = 1500;
	localparam int IDLE_PCT     = 27;
	localparam int HOLD_CYCLES  = 200;

	typedef struct packed {
		logic                  granted;
		logic [FIELD_BITS-1:0] slot_index;
	} palette_grant_t;

	class palette_slot_predictor;
		logic                  slot_taken [NUM_SLOTS];
		logic [OWNER_BITS-1:0] slot_owner [NUM_SLOTS];
		palette_grant_t        expected_grants [$];
		int                    errors;

		function new();
			for (int k = 0; k < NUM_SLOTS; k++) begin
				slot_taken[k] = 1'b0;
				slot_owner[k] = '0;
			end
			errors = 0;
		endfunction

		// Scan from slot 0: the first free slot starts a fresh claim, and the
		// first slot already held by the same owner is granted as it is.
		function void note_request(logic [FIELD_BITS-1:0] otype, logic [FIELD_BITS-1:0] cnt);
			palette_grant_t        grant;
			logic [OWNER_BITS-1:0] owner;
			bit                    found;
			grant = '{granted: 1'b0, slot_index: '0};
			owner = otype[OWNER_BITS-1:0];
			found = 1'b0;
			for (int k = 0; k < NUM_SLOTS && !found; k++) begin
				if (!slot_taken[k]) begin
					for (int m = 0; m < int'(cnt); m++) begin
						if (k + m < NUM_SLOTS) begin
							slot_taken[k + m] = 1'b1;
							slot_owner[k + m] = owner;
						end
					end
					found = 1'b1;
				end else if (slot_owner[k] == owner) begin
					found = 1'b1;
				end
				if (found)
					grant = '{granted: 1'b1, slot_index: k[FIELD_BITS-1:0]};
			end
			expected_grants.push_back(grant);
		endfunction

		function void check_grant(logic got_granted, logic [FIELD_BITS-1:0] got_slot);
			palette_grant_t want;
			if (expected_grants.size() == 0) begin
				$error("result transfer with no request outstanding: granted=%0d slot_index=%0d",
					got_granted, got_slot);
				errors++;
				return;
			end
			want = expected_grants.pop_front();
			if (got_granted !== want.granted) begin
				$error("granted: expected %0d, actual %0d", want.granted, got_granted);
				errors++;
			end
			if (got_slot !== want.slot_index) begin
				$error("slot_index: expected %0d, actual %0d", want.slot_index, got_slot);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_grants.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [FIELD_BITS-1:0] owner_type = '0;
	logic [FIELD_BITS-1:0] claim_count = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  granted;
	logic [FIELD_BITS-1:0] slot_index;

	palette_slot_predictor allocator = new();
	int                    results_seen = 0;

	shared_palette_slot_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.owner_type  (owner_type),
		.claim_count (claim_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.granted     (granted),
		.slot_index  (slot_index)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** shared_palette_slot_allocator: FAILED **");
		$finish;
	end

	// Presents one request and returns at the edge where it transfers. Valid
	// stays high afterwards; the caller lowers it only when a gap follows.
	task automatic send_request(input logic [FIELD_BITS-1:0] otype,
			input logic [FIELD_BITS-1:0] cnt);
		in_valid    <= 1'b1;
		owner_type  <= otype;
		claim_count <= cnt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		allocator.note_request(otype, cnt);
	endtask

	task automatic maybe_idle(input bit allow);
		if (allow && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (allocator.outstanding() != 0)
			@(posedge clk);
	endtask

	// Receiver: checks each result transfer, then picks the stall for the
	// next cycle. One long hold-off lets the block fill and stall its input.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				allocator.check_grant(granted, slot_index);
				results_seen++;
			end
			if (!hold_done && results_seen >= 300) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_seen >= 1000 && results_seen < 1300) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	initial begin
		logic [FIELD_BITS-1:0] dir_owner [14];
		logic [FIELD_BITS-1:0] dir_count [14];

		// Fresh table: a zero-count grant that claims nothing, a match on an
		// owned slot, owner zero, a claim cut off at the end of the table,
		// then refusals and matches on the full table.
		dir_owner = '{4'd0, 4'd5, 4'd5,  4'd0, 4'd0, 4'd15, 4'd15,
			4'd15, 4'd10, 4'd7, 4'd10, 4'd15, 4'd0,  4'd9};
		dir_count = '{4'd0, 4'd3, 4'd15, 4'd1, 4'd0, 4'd0,  4'd10,
			4'd1,  4'd15, 4'd1, 4'd0,  4'd15, 4'd15, 4'd15};

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 14; i++) begin
			maybe_idle(1'b1);
			send_request(dir_owner[i], dir_count[i]);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 800)
				wait_for_drain();
			else
				maybe_idle(i < 1000 || i >= 1300);
			send_request(FIELD_BITS'($urandom_range(0, 15)),
				FIELD_BITS'($urandom_range(0, 15)));
		end

		wait_for_drain();
		repeat (10)
			@(posedge clk);

		if (allocator.errors == 0 && allocator.outstanding() == 0)
			$display("** shared_palette_slot_allocator: PASSED **");
		else
			$display("** shared_palette_slot_allocator: FAILED **");
		$finish;
	end

endmodule

// ===== shared_palette_slot_allocator.f =====
+incdir+rtl
rtl/spsa_pkg.sv
rtl/spsa_datapath.sv
rtl/spsa_controller.sv
rtl/shared_palette_slot_allocator.sv
tb/sv/tb.sv
